### rtl/prb_pkg.sv
// Shared constants and control types for the presentation-order reorder buffer.
package prb_pkg;

  localparam int unsigned DepthDefault   = 16;
  localparam int unsigned TagBitsDefault = 8;
  localparam int unsigned TimeBits       = 33;

  typedef logic [TimeBits-1:0] time_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic  ins;       // insert the request's frame this cycle
    logic  clr;       // list full: drop contents before the insert
    logic  drain;     // shift one entry toward the output
    time_t new_time;  // sort key of the frame being inserted
  } cell_ctl_t;

endpackage

### rtl/pts_reorder_buffer.sv
// Top level: sorted insertion chain that reorders frames into presentation order.
//
//   channel | handshake                 | payload
//   in      | in_valid_i / in_stall_o   | frame_tag_i, pts_valid_i, pres_time_i,
//           |                           | dts_valid_i, decode_time_i
//   out     | out_valid_o / out_stall_i | out_tag_o, out_time_o, last_of_flush_o
//
// A frame is inserted into the chain in the cycle its request is taken; every cell
// compares its key against the new one in parallel. A flushing frame is followed
// by a drain of N results (N = entries held), one per cycle at the head cell while
// out_stall_i is low; in_stall_o stays high until the last one is taken. Reset
// empties the chain. While draining, out_stall_i freezes the chain and head's payload.
module pts_reorder_buffer import prb_pkg::*; #(
  parameter int unsigned DEPTH    = DepthDefault,
  parameter int unsigned TAG_BITS = TagBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [TAG_BITS-1:0] frame_tag_i,
  input  logic                pts_valid_i,
  input  time_t               pres_time_i,
  input  logic                dts_valid_i,
  input  time_t               decode_time_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [TAG_BITS-1:0] out_tag_o,
  output time_t               out_time_o,
  output logic                last_of_flush_o
);

  logic                drain_q, drain_d;
  logic                in_acc, out_acc, flush;
  cell_ctl_t           ctl;

  logic [DEPTH-1:0]    valid, gt;
  logic [TAG_BITS-1:0] tags  [DEPTH];
  time_t               times [DEPTH];

  assign in_stall_o = drain_q;
  assign in_acc     = in_valid_i && !drain_q;
  assign out_valid_o = drain_q && valid[0];
  assign out_acc    = out_valid_o && !out_stall_i;

  // missing pts: both stamps zero; missing dts: equal to pts
  assign flush = !pts_valid_i || !dts_valid_i || (pres_time_i == decode_time_i);

  always_comb begin
    ctl.ins      = in_acc;
    ctl.clr      = in_acc && valid[DEPTH-1];
    ctl.drain    = out_acc;
    ctl.new_time = pts_valid_i ? pres_time_i : '0;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                lv, lg, rv;
    logic [TAG_BITS-1:0] lt, rt;
    time_t               ltm, rtm;

    if (g == 0) begin : g_head
      assign lv  = 1'b1;
      assign lg  = 1'b0;
      assign lt  = frame_tag_i;
      assign ltm = ctl.new_time;
    end else begin : g_mid
      // a cleared neighbor counts as empty
      assign lv  = valid[g-1] & ~ctl.clr;
      assign lg  = gt[g-1];
      assign lt  = tags[g-1];
      assign ltm = times[g-1];
    end

    if (g == DEPTH-1) begin : g_tail
      assign rv  = 1'b0;
      assign rt  = tags[g];
      assign rtm = times[g];
    end else begin : g_body
      assign rv  = valid[g+1];
      assign rt  = tags[g+1];
      assign rtm = times[g+1];
    end

    prb_cell #(
      .TAG_BITS(TAG_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .new_tag_i    (frame_tag_i),
      .left_valid_i (lv),
      .left_gt_i    (lg),
      .left_tag_i   (lt),
      .left_time_i  (ltm),
      .right_valid_i(rv),
      .right_tag_i  (rt),
      .right_time_i (rtm),
      .valid_o      (valid[g]),
      .gt_o         (gt[g]),
      .tag_o        (tags[g]),
      .time_o       (times[g])
    );
  end

  always_comb begin
    drain_d = drain_q;
    if (in_acc && flush) begin
      drain_d = 1'b1;
    end else if (out_acc && !valid[1]) begin
      drain_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q <= 1'b0;
    end else begin
      drain_q <= drain_d;
    end
  end

  assign out_tag_o       = tags[0];
  assign out_time_o      = times[0];
  assign last_of_flush_o = !valid[1];

endmodule

### rtl/prb_cell.sv
// One slot of the sorted chain: holds a frame and trades with its neighbors.
module prb_cell import prb_pkg::*; #(
  parameter int unsigned TAG_BITS = TagBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cell_ctl_t           ctl_i,
  input  logic [TAG_BITS-1:0] new_tag_i,
  input  logic                left_valid_i,
  input  logic                left_gt_i,
  input  logic [TAG_BITS-1:0] left_tag_i,
  input  time_t               left_time_i,
  input  logic                right_valid_i,
  input  logic [TAG_BITS-1:0] right_tag_i,
  input  time_t               right_time_i,
  output logic                valid_o,
  output logic                gt_o,
  output logic [TAG_BITS-1:0] tag_o,
  output time_t               time_o
);

  logic                valid_q, valid_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;
  time_t               time_q, time_d;
  logic                eff_valid, take_new;

  assign eff_valid = valid_q & ~ctl_i.clr;
  assign gt_o      = eff_valid && (ctl_i.new_time < time_q);
  // first slot holding a larger key, or first empty slot when none is larger;
  // left_valid_i already reflects a clear of the list
  assign take_new  = (gt_o || !eff_valid) && left_valid_i && !left_gt_i;

  always_comb begin
    valid_d = valid_q;
    tag_d   = tag_q;
    time_d  = time_q;
    if (ctl_i.ins) begin
      valid_d = eff_valid;
      if (left_gt_i) begin
        valid_d = 1'b1;
        tag_d   = left_tag_i;
        time_d  = left_time_i;
      end else if (take_new) begin
        valid_d = 1'b1;
        tag_d   = new_tag_i;
        time_d  = ctl_i.new_time;
      end
    end else if (ctl_i.drain) begin
      valid_d = right_valid_i;
      tag_d   = right_tag_i;
      time_d  = right_time_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q  <= tag_d;
    time_q <= time_d;
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign time_o  = time_q;

endmodule
